@@ design/rau_pkg.sv @@
// rau_pkg: shared types and codes for the rational arithmetic unit.
// No dependencies.
package rau_pkg;

  localparam int unsigned FieldW = 64;
  localparam int unsigned DenOutW = 63;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_CMP = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  // classification made by the front part
  typedef enum logic [1:0] {
    CLS_NOP  = 2'd0,
    CLS_ZERO = 2'd1,
    CLS_OVF  = 2'd2,
    CLS_RUN  = 2'd3
  } cls_t;

  // back-part sequencer states
  typedef enum logic [3:0] {
    B_IDLE, B_GCD, B_DIV, B_MUL, B_STEP, B_OUT
  } bstate_t;

  // item passed from front to back: op, class, signs and magnitudes
  typedef struct packed {
    logic [2:0]        op;
    cls_t              cls;
    logic [3:0]        neg;
    logic [FieldW-1:0] m0;
    logic [FieldW-1:0] m1;
    logic [FieldW-1:0] m2;
    logic [FieldW-1:0] m3;
  } job_t;

  typedef struct packed {
    logic [FieldW-1:0]  num;
    logic [DenOutW-1:0] den;
    logic [1:0]         order;
    logic [1:0]         status;
  } res_t;

endpackage

@@ design/rau_front.sv @@
// rau_front: accepts items, splits operands into sign/magnitude and classifies.
// Depends on rau_pkg.
module rau_front import rau_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             op,
  input  logic [4*FieldW-1:0]    raw,
  output logic                   q_valid,
  input  logic                   q_ready,
  output job_t                   q_job
);

  localparam int unsigned W = VALUE_WIDTH;

  logic [3:0]        ng;
  logic [FieldW-1:0] mg [4];
  logic              lim_bad;
  logic              zero_bad;
  job_t              job;

  always_comb begin
    logic [W-1:0] v;
    for (int i = 0; i < 4; i++) begin
      v = raw[i*FieldW +: W];
      ng[i] = v[W-1];
      mg[i] = FieldW'(v[W-1] ? (~v + W'(1)) : v);
    end
  end

  // most negative value keeps its sign bit after negation
  always_comb begin
    lim_bad = 1'b0;
    for (int i = 0; i < 4; i++) lim_bad = lim_bad | mg[i][W-1];
  end

  assign zero_bad = (mg[1] == '0) || (mg[3] == '0) || (op == OP_DIV && mg[2] == '0);

  always_comb begin
    job.op  = op;
    job.neg = ng;
    job.m0  = mg[0];
    job.m1  = mg[1];
    job.m2  = mg[2];
    job.m3  = mg[3];
    if (op > OP_CMP) job.cls = CLS_NOP;
    else if (zero_bad) job.cls = CLS_ZERO;
    else if (lim_bad) job.cls = CLS_OVF;
    else job.cls = CLS_RUN;
  end

  // one-entry queue register between front and back
  assign in_ready = !q_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_job <= job;
    end
  end

endmodule

@@ design/rau_back.sv @@
// rau_back: microcoded sequencer with shared iterative GCD/divide and multiply units.
// Depends on rau_pkg.
module rau_back import rau_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  output logic  q_ready,
  input  job_t  q_job,
  output logic  r_valid,
  input  logic  r_ready,
  output res_t  r_res
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(2*W+1);
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};

  // register file of working values
  // 0 an,1 ad,2 bn,3 bd, 4..15 scratch
  logic [W-1:0] rf [16];
  logic         an_neg, bn_neg, sneg;
  logic [2:0]   op;
  logic         ovf;
  logic [4:0]   pc;
  bstate_t      state, state_next;

  // shared unit operands / results
  logic [W-1:0]   ua, ub;
  logic [2*W-1:0] acc;      // multiply accumulator, or rem:quo for divide
  logic [W-1:0]   dq;
  logic [CW-1:0]  cnt;
  logic [3:0]     dst;

  // microprogram: each step is (kind, src a, src b, dst)
  // kind: 0 gcd, 1 div, 2 cmul (checked product), 3 wide mul (keep 2W)
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] sa;
    logic [3:0] sb;
    logic [3:0] d;
  } uop_t;

  uop_t        u;

  // program selection by pc: normalize steps shared by all ops
  always_comb begin
    u = '0;
    case (pc)
      // normalize a and b
      5'd0: u = '{2'd0, 4'd0, 4'd1, 4'd4};   // g = gcd(an,ad)
      5'd1: u = '{2'd1, 4'd0, 4'd4, 4'd0};
      5'd2: u = '{2'd1, 4'd1, 4'd4, 4'd1};
      5'd3: u = '{2'd0, 4'd2, 4'd3, 4'd4};
      5'd4: u = '{2'd1, 4'd2, 4'd4, 4'd2};
      5'd5: u = '{2'd1, 4'd3, 4'd4, 4'd3};
      default: u = '0;
    endcase
  end

  // The remainder of the algorithm is run as a fixed step list in the
  // sequencer below; step index pc selects operation.
  logic [3:0]  s_a, s_b, s_d;
  logic [1:0]  s_k;
  logic        s_end;

  always_comb begin
    s_k = u.kind; s_a = u.sa; s_b = u.sb; s_d = u.d; s_end = 1'b0;
    if (pc >= 5'd6) begin
      s_end = 1'b0;
      case (op)
        OP_MUL: begin
          case (pc)
            5'd6:  begin s_k = 2'd0; s_a = 4'd0; s_b = 4'd3; s_d = 4'd5; end
            5'd7:  begin s_k = 2'd0; s_a = 4'd1; s_b = 4'd2; s_d = 4'd6; end
            5'd8:  begin s_k = 2'd1; s_a = 4'd0; s_b = 4'd5; s_d = 4'd7; end
            5'd9:  begin s_k = 2'd1; s_a = 4'd2; s_b = 4'd6; s_d = 4'd8; end
            5'd10: begin s_k = 2'd1; s_a = 4'd3; s_b = 4'd5; s_d = 4'd9; end
            5'd11: begin s_k = 2'd1; s_a = 4'd1; s_b = 4'd6; s_d = 4'd10; end
            5'd12: begin s_k = 2'd2; s_a = 4'd7; s_b = 4'd8; s_d = 4'd11; end
            5'd13: begin s_k = 2'd2; s_a = 4'd9; s_b = 4'd10; s_d = 4'd12; end
            default: s_end = 1'b1;
          endcase
        end
        OP_DIV: begin
          case (pc)
            5'd6:  begin s_k = 2'd0; s_a = 4'd0; s_b = 4'd2; s_d = 4'd5; end
            5'd7:  begin s_k = 2'd0; s_a = 4'd1; s_b = 4'd3; s_d = 4'd6; end
            5'd8:  begin s_k = 2'd1; s_a = 4'd0; s_b = 4'd5; s_d = 4'd7; end
            5'd9:  begin s_k = 2'd1; s_a = 4'd3; s_b = 4'd6; s_d = 4'd8; end
            5'd10: begin s_k = 2'd1; s_a = 4'd2; s_b = 4'd5; s_d = 4'd9; end
            5'd11: begin s_k = 2'd1; s_a = 4'd1; s_b = 4'd6; s_d = 4'd10; end
            5'd12: begin s_k = 2'd2; s_a = 4'd7; s_b = 4'd8; s_d = 4'd11; end
            5'd13: begin s_k = 2'd2; s_a = 4'd9; s_b = 4'd10; s_d = 4'd12; end
            default: s_end = 1'b1;
          endcase
        end
        OP_ADD, OP_SUB: begin
          // gn(5) gd(6) t1(11) t2(12) s(2); then mul (gn/(ad/gd)) * (s/bd)
          case (pc)
            5'd6:  begin s_k = 2'd0; s_a = 4'd0; s_b = 4'd2; s_d = 4'd5; end
            5'd7:  begin s_k = 2'd0; s_a = 4'd1; s_b = 4'd3; s_d = 4'd6; end
            5'd8:  begin s_k = 2'd1; s_a = 4'd0; s_b = 4'd5; s_d = 4'd7; end
            5'd9:  begin s_k = 2'd1; s_a = 4'd3; s_b = 4'd6; s_d = 4'd8; end
            5'd10: begin s_k = 2'd1; s_a = 4'd2; s_b = 4'd5; s_d = 4'd9; end
            5'd11: begin s_k = 2'd1; s_a = 4'd1; s_b = 4'd6; s_d = 4'd10; end
            5'd12: begin s_k = 2'd2; s_a = 4'd7; s_b = 4'd8; s_d = 4'd11; end
            5'd13: begin s_k = 2'd2; s_a = 4'd9; s_b = 4'd10; s_d = 4'd12; end
            // pc 14 is the signed add step; operands now 0:=gn 1:=ad/gd 2:=s 3:=bd
            5'd15: begin s_k = 2'd0; s_a = 4'd2; s_b = 4'd3; s_d = 4'd4; end
            5'd16: begin s_k = 2'd1; s_a = 4'd2; s_b = 4'd4; s_d = 4'd2; end
            5'd17: begin s_k = 2'd1; s_a = 4'd3; s_b = 4'd4; s_d = 4'd3; end
            // make(false, gn, ad/gd): gn and ad/gd are coprime already
            5'd18: begin s_k = 2'd0; s_a = 4'd0; s_b = 4'd3; s_d = 4'd5; end
            5'd19: begin s_k = 2'd0; s_a = 4'd1; s_b = 4'd2; s_d = 4'd6; end
            5'd20: begin s_k = 2'd1; s_a = 4'd0; s_b = 4'd5; s_d = 4'd7; end
            5'd21: begin s_k = 2'd1; s_a = 4'd2; s_b = 4'd6; s_d = 4'd8; end
            5'd22: begin s_k = 2'd1; s_a = 4'd3; s_b = 4'd5; s_d = 4'd9; end
            5'd23: begin s_k = 2'd1; s_a = 4'd1; s_b = 4'd6; s_d = 4'd10; end
            5'd24: begin s_k = 2'd2; s_a = 4'd7; s_b = 4'd8; s_d = 4'd11; end
            5'd25: begin s_k = 2'd2; s_a = 4'd9; s_b = 4'd10; s_d = 4'd12; end
            default: s_end = 1'b1;
          endcase
        end
        OP_CMP: begin
          case (pc)
            5'd6: begin s_k = 2'd3; s_a = 4'd0; s_b = 4'd3; s_d = 4'd11; end
            5'd7: begin s_k = 2'd3; s_a = 4'd2; s_b = 4'd1; s_d = 4'd13; end
            default: s_end = 1'b1;
          endcase
        end
        default: s_end = 1'b1;
      endcase
    end
  end

  logic [W-1:0] opa, opb;
  assign opa = rf[s_a];
  assign opb = rf[s_b];

  // restoring divider step
  logic [W:0]   rem_sh;
  logic [W:0]   rem_sub;
  assign rem_sh  = {acc[2*W-1:W], acc[W-1]};
  assign rem_sub = rem_sh - {1'b0, ub};

  assign q_ready = (state == B_IDLE) && !r_valid;
  assign dq = acc[W-1:0];

  // single-step decisions taken in B_STEP
  logic eq_done, cmp_split, sum_step;
  assign eq_done   = (pc == 5'd6) && (op == OP_EQ);
  assign cmp_split = (pc == 5'd6) && (op == OP_CMP) &&
                     ((rf[0] != '0 && an_neg) != (rf[2] != '0 && bn_neg));
  assign sum_step  = (pc == 5'd14) && (op == OP_ADD || op == OP_SUB);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: if (q_valid && q_ready && q_job.cls == CLS_RUN) state_next = B_STEP;
      B_STEP: begin
        if (eq_done || cmp_split) begin
          state_next = B_IDLE;
        end else if (sum_step) begin
          state_next = B_STEP;
        end else if (s_end) begin
          state_next = B_OUT;
        end else begin
          case (s_k)
            2'd0: if (!(opa == '0 && opb == '0)) state_next = B_GCD;
            2'd1: state_next = B_DIV;
            default: state_next = B_MUL;
          endcase
        end
      end
      B_GCD: if (ub == '0) state_next = B_STEP;
      B_DIV: if (cnt >= CW'(W)) state_next = B_STEP;
      B_MUL: if (cnt >= CW'(W)) state_next = B_STEP;
      B_OUT: state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // the sequencer is written as one clocked process for the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      r_valid <= 1'b0;
      pc      <= '0;
    end else begin
      state <= state_next;
      if (r_valid && r_ready) r_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (q_valid && q_ready) begin
            op <= q_job.op;
            ovf <= 1'b0;
            pc <= '0;
            an_neg <= q_job.neg[0] ^ q_job.neg[1];
            bn_neg <= q_job.neg[2] ^ q_job.neg[3];
            rf[0] <= q_job.m0[W-1:0];
            rf[1] <= q_job.m1[W-1:0];
            rf[2] <= q_job.m2[W-1:0];
            rf[3] <= q_job.m3[W-1:0];
            if (q_job.cls == CLS_RUN) begin
              r_res <= '0;
            end else begin
              r_res <= '{num: '0, den: '0, order: ORD_LT,
                         status: (q_job.cls == CLS_ZERO) ? ST_ZERO :
                                 (q_job.cls == CLS_OVF) ? ST_OVF : ST_OK};
              r_valid <= 1'b1;
            end
          end
        end
        B_STEP: begin
          if (eq_done) begin
            r_res.order <= (an_neg == bn_neg || (rf[0] == '0)) &&
                           rf[0] == rf[2] && rf[1] == rf[3] &&
                           ((rf[0] == '0) || an_neg == bn_neg) ? ORD_EQ : ORD_LT;
            r_valid <= 1'b1;
          end else if (cmp_split) begin
            r_res.order <= (rf[0] != '0 && an_neg) ? ORD_LT : ORD_GT;
            r_valid <= 1'b1;
          end else if (sum_step) begin
            // signed sum of t1 and t2; b sign flips for subtract
            if (an_neg == (bn_neg ^ (op == OP_SUB && rf[2] != '0) ^
                (op == OP_SUB && rf[2] == '0 && 1'b0))) begin
              if (rf[11] > VMAX - rf[12]) begin ovf <= 1'b1; rf[2] <= '0; end
              else rf[2] <= rf[11] + rf[12];
              sneg <= an_neg;
            end else if (rf[11] >= rf[12]) begin
              rf[2] <= rf[11] - rf[12]; sneg <= an_neg;
            end else begin
              rf[2] <= rf[12] - rf[11];
              sneg <= bn_neg ^ (op == OP_SUB && rf[2] != '0);
            end
            rf[0] <= rf[5];
            rf[1] <= rf[10];
            pc <= pc + 5'd1;
          end else if (!s_end) begin
            ua  <= opa;
            ub  <= opb;
            dst <= s_d;
            cnt <= '0;
            case (s_k)
              2'd0: begin
                if (opa == '0 && opb == '0) begin
                  rf[s_d] <= W'(1); pc <= pc + 5'd1;
                end
              end
              2'd1: acc <= {{W{1'b0}}, opa};
              default: acc <= '0;
            endcase
            // the add path remaps operand signs before its final multiply
            if (pc == 5'd15 && (op == OP_ADD || op == OP_SUB)) begin
              an_neg <= 1'b0;
              bn_neg <= sneg;
            end
          end
        end
        B_GCD: begin
          // Euclid: ua, ub -> ub, ua % ub, remainder by bit-serial divide
          if (ub == '0) begin
            rf[dst] <= ua;
            pc <= pc + 5'd1;
          end else if (cnt == '0) begin
            acc <= {{W{1'b0}}, ua};
            cnt <= CW'(1);
          end else if (cnt <= CW'(W)) begin
            if (!rem_sub[W]) acc <= {rem_sub[W-1:0], acc[W-2:0], 1'b1};
            else acc <= {rem_sh[W-1:0], acc[W-2:0], 1'b0};
            cnt <= cnt + CW'(1);
          end else begin
            ua <= ub;
            ub <= acc[2*W-1:W];
            cnt <= '0;
          end
        end
        B_DIV: begin
          if (cnt < CW'(W)) begin
            if (!rem_sub[W]) acc <= {rem_sub[W-1:0], acc[W-2:0], 1'b1};
            else acc <= {rem_sh[W-1:0], acc[W-2:0], 1'b0};
            cnt <= cnt + CW'(1);
          end else begin
            rf[dst] <= dq;
            pc <= pc + 5'd1;
          end
        end
        B_MUL: begin
          // shift-add, one multiplier bit per cycle from the top
          if (cnt < CW'(W)) begin
            acc <= (acc << 1) + (ub[W-1-cnt[CW-2:0]] ? {{W{1'b0}}, ua} : '0);
            cnt <= cnt + CW'(1);
          end else begin
            if (s_k == 2'd3) begin
              rf[dst] <= acc[2*W-1:W];
              rf[dst+4'd1] <= acc[W-1:0];
            end else begin
              if (acc > {{W{1'b0}}, VMAX}) begin
                ovf <= 1'b1; rf[dst] <= '0;
              end else rf[dst] <= acc[W-1:0];
            end
            pc <= pc + 5'd1;
          end
        end
        B_OUT: begin
          if (op == OP_CMP) begin
            if ({rf[11], rf[12]} == {rf[13], rf[14]}) r_res.order <= ORD_EQ;
            else if (({rf[11], rf[12]} < {rf[13], rf[14]}) != (an_neg && rf[0] != '0))
              r_res.order <= ORD_LT;
            else r_res.order <= ORD_GT;
          end else if (ovf) begin
            r_res.status <= ST_OVF;
          end else begin
            // make(): den never zero here; numerators already coprime
            r_res <= '{num: FieldW'($signed((an_neg ^ bn_neg) && rf[11] != '0 ?
                                   (~rf[11] + W'(1)) : rf[11])),
                       den: DenOutW'(rf[11] == '0 ? W'(1) : rf[12]),
                       order: ORD_LT,
                       status: ST_OK};
          end
          r_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |=> !q_ready) else $error("back accepted twice");
  a_out_idle: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid) else $error("result dropped");
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_res.status != ST_OK |-> r_res.num == '0 && r_res.den == '0)
    else $error("error result carries data");

endmodule

@@ design/rational_arith_unit.sv @@
// rational_arith_unit: top level, front classifier + back sequencer.
// Depends on rau_pkg, rau_front, rau_back.
//
// Usage:
//   s_axis_* carries one item: tuser = req_type, tdata = a_num, a_den,
//   b_num, b_den (64 bits each, low to high). m_axis_* returns one result per
//   item: tdata = res_num[63:0], res_den[126:64], order[128:127],
//   status[130:129], zero padded to 136 bits.
//   An item passes through the front register, then the back part runs a
//   microprogram of GCDs, divides and multiplies on a shared bit-serial
//   unit, a GCD doing one bit-serial divide per Euclid round. Flagged or
//   unknown items put out their result in the cycle after the back part
//   takes them. The shared unit sets the rate: one item in the back part at
//   a time.
//   The front register takes the next item while the back part works.
//   Reset clears all valid flags; a stalled m_axis_tready holds the result
//   and the back part waits.
module rational_arith_unit import rau_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
  input  logic [2:0]   s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata   // res_num, res_den, order, status
);

  logic q_valid, q_ready;
  job_t q_job;
  res_t res;

  rau_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .op(s_axis_tuser), .raw(s_axis_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
  );

  rau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
    .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_res(res)
  );

  assign m_axis_tdata = {5'd0, res.status, res.order, res.den, res.num};

endmodule
